@@ hw/rtl/skat_pkg.sv @@
// Package for the sorted key accumulate table: widths, action and status codes.
// No dependencies.
package skat_pkg;
    localparam int Entries  = 256;
    localparam int KeyBits  = 16;
    localparam int QtyBits  = 48;
    localparam int IdxBits  = $clog2(Entries);
    localparam int CntBits  = IdxBits + 1;
    localparam int RowBits  = KeyBits + 4 * QtyBits;

    typedef enum logic [2:0] {
        ACT_GET_KEY = 3'd0,
        ACT_SET_KEY = 3'd1,
        ACT_ADD_KEY = 3'd2,
        ACT_GET_POS = 3'd3,
        ACT_SET_POS = 3'd4,
        ACT_REM_POS = 3'd5,
        ACT_CLEAR   = 3'd6,
        ACT_NONE    = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_SAT  = 2'd3
    } t_status;
endpackage

@@ hw/rtl/skat_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module skat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ hw/rtl/sorted_key_accumulate_table_core.sv @@
// Top level of the sorted key accumulate table: sequencer, one shared adder, entry RAM.
// Depends on skat_pkg and skat_ram.
//
// channel | dir | tdata fields (low bit first)                         | tuser
// s_axis  | in  | action, key, position, qty_in, qty_out, stk_in, stk_out | -
// m_axis  | out | status, found, where, key_out, four quantities, count | -
//
// Keyed actions search with up to log2(Entries)+1 probes, each a probe and a compare state
// (one RAM read port). Insert/remove shift one row at a time, a read state then a write.
// Add runs the four quantities through one saturating adder, one per cycle.
// Worst case is an insert at the front of a nearly full table.
// Ready only in idle; a finished result sits in the output register while the
// next transaction may be taken. Synchronous active-low reset clears the count.
module sorted_key_accumulate_table_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[2:0], key[18:3], position[26:19], qty_in[74:27], qty_out[122:75],
    // stocktake_in[170:123], stocktake_out[218:171], zero pad
    input  logic [223:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], found[2], where[11:3], key_out[27:12], qty_in_out[75:28],
    // qty_out_out[123:76], stocktake_in_out[171:124], stocktake_out_out[219:172],
    // entry_count[228:220], zero pad
    output logic [231:0] m_axis_tdata
);
    import skat_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PROBE, S_CMP, S_DECIDE, S_SHR_RD, S_SHR_WR, S_SHL_RD, S_SHL_WR,
        S_RD, S_RDW, S_ADD, S_WRITE, S_OUT
    } t_state;

    localparam logic signed [CntBits:0] BoundOne = 1;

    t_state                r_state;
    t_action               r_act;
    logic [KeyBits-1:0]    r_key;
    logic [7:0]            r_pos;
    logic [QtyBits-1:0]    r_q [4];
    logic [CntBits-1:0]    r_cnt;
    logic signed [CntBits:0] r_s, r_e;
    logic [IdxBits-1:0]    r_idx;
    logic [CntBits-1:0]    r_ptr;
    logic [1:0]            r_qi;
    logic                  r_found, r_sat;
    logic [RowBits-1:0]    r_row;
    logic [1:0]            r_status;
    logic [8:0]            r_where;
    logic                  r_ovalid;
    logic [231:0]          r_odata;

    logic                  ram_we;
    logic [IdxBits-1:0]    ram_addr;
    logic [RowBits-1:0]    ram_wdata, ram_rdata;

    skat_ram #(.WIDTH(RowBits), .DEPTH(Entries)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    // search midpoint; both bounds nonnegative while probing
    logic signed [CntBits+1:0] mid_sum;
    logic [IdxBits-1:0]        mid;
    assign mid_sum = {r_s[CntBits], r_s} + {r_e[CntBits], r_e};
    assign mid     = mid_sum[IdxBits:1];

    logic [KeyBits-1:0] rd_key;
    assign rd_key = ram_rdata[KeyBits-1:0];

    // shared saturating adder, one quantity per cycle
    logic [QtyBits-1:0] add_a, add_b, add_s, add_r;
    logic               add_ovf;
    assign add_a   = r_row[KeyBits + r_qi*QtyBits +: QtyBits];
    assign add_b   = r_q[r_qi];
    assign add_s   = add_a + add_b;
    assign add_ovf = (add_a[QtyBits-1] == add_b[QtyBits-1]) &&
                     (add_s[QtyBits-1] != add_a[QtyBits-1]);
    assign add_r   = !add_ovf ? add_s :
                     add_a[QtyBits-1] ? {1'b1, {(QtyBits-1){1'b0}}}
                                      : {1'b0, {(QtyBits-1){1'b1}}};

    logic [RowBits-1:0] in_row;
    assign in_row = {r_q[3], r_q[2], r_q[1], r_q[0], r_key};

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // shifts copy the row just read straight back one slot over
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_idx;
        ram_wdata = r_row;
        unique case (r_state)
            S_PROBE:  ram_addr = mid;
            S_SHR_RD: ram_addr = IdxBits'(r_ptr - 1'b1);
            S_SHR_WR: begin
                ram_we    = 1'b1;
                ram_addr  = r_ptr[IdxBits-1:0];
                ram_wdata = ram_rdata;
            end
            S_SHL_RD: ram_addr = IdxBits'(r_ptr + 1'b1);
            S_SHL_WR: begin
                ram_we    = 1'b1;
                ram_addr  = r_ptr[IdxBits-1:0];
                ram_wdata = ram_rdata;
            end
            S_WRITE:  ram_we = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // output register: loaded from S_OUT when free, dropped on handshake
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_act    <= t_action'(s_axis_tdata[2:0]);
                        r_key    <= s_axis_tdata[18:3];
                        r_pos    <= s_axis_tdata[26:19];
                        r_q[0]   <= s_axis_tdata[74:27];
                        r_q[1]   <= s_axis_tdata[122:75];
                        r_q[2]   <= s_axis_tdata[170:123];
                        r_q[3]   <= s_axis_tdata[218:171];
                        r_s      <= '0;
                        r_e      <= $signed({1'b0, r_cnt}) - BoundOne;
                        r_found  <= 1'b0;
                        r_sat    <= 1'b0;
                        r_status <= ST_DONE;
                        r_where  <= '0;
                        r_qi     <= '0;
                        if (s_axis_tdata[2:0] <= ACT_ADD_KEY && r_cnt != '0) begin
                            r_state <= S_PROBE;
                        end else begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_PROBE: begin
                    r_idx   <= mid;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_key > rd_key) r_s <= $signed({2'b0, r_idx}) + BoundOne;
                    else if (r_key < rd_key) r_e <= $signed({2'b0, r_idx}) - BoundOne;
                    else r_found <= 1'b1;
                    if (r_key == rd_key) r_state <= S_DECIDE;
                    else if ((r_key > rd_key) ? ($signed({2'b0, r_idx}) + BoundOne <= r_e)
                                              : (r_s <= $signed({2'b0, r_idx}) - BoundOne))
                        r_state <= S_PROBE;
                    else r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    unique case (r_act) inside
                        ACT_GET_KEY, ACT_SET_KEY, ACT_ADD_KEY: begin
                            if (r_found) begin
                                r_where <= 9'(r_idx);
                                r_state <= S_RD;
                            end else begin
                                r_where <= 9'(r_s);
                                r_idx   <= IdxBits'(r_s);
                                if (r_act == ACT_GET_KEY) begin
                                    r_status <= ST_MISS;
                                    r_state  <= S_OUT;
                                end else if (r_cnt >= CntBits'(Entries)) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_ptr   <= r_cnt;
                                    r_row   <= in_row;
                                    r_state <= (r_cnt > CntBits'(r_s)) ? S_SHR_RD : S_WRITE;
                                end
                            end
                        end
                        ACT_GET_POS, ACT_SET_POS, ACT_REM_POS: begin
                            r_where <= 9'(r_pos);
                            if (CntBits'(r_pos) < r_cnt) begin
                                r_found <= 1'b1;
                                r_idx   <= IdxBits'(r_pos);
                                r_state <= S_RD;
                            end else begin
                                r_status <= ST_MISS;
                                r_state  <= S_OUT;
                            end
                        end
                        ACT_CLEAR: begin
                            r_cnt   <= '0;
                            r_state <= S_OUT;
                        end
                        default: begin
                            r_status <= ST_MISS;
                            r_state  <= S_OUT;
                        end
                    endcase
                end
                S_SHR_RD: r_state <= S_SHR_WR;
                S_SHR_WR: begin
                    r_ptr   <= r_ptr - 1'b1;
                    r_state <= (r_ptr - 1'b1 > CntBits'(r_idx)) ? S_SHR_RD : S_WRITE;
                end
                S_RD: r_state <= S_RDW;
                S_RDW: begin
                    unique case (r_act) inside
                        ACT_SET_KEY, ACT_SET_POS: begin
                            r_row   <= in_row;
                            r_state <= S_WRITE;
                        end
                        ACT_ADD_KEY: begin
                            r_row   <= ram_rdata;
                            r_state <= S_ADD;
                        end
                        ACT_REM_POS: begin
                            r_row   <= ram_rdata;
                            r_ptr   <= CntBits'(r_idx);
                            r_state <= (CntBits'(r_idx) + 1'b1 < r_cnt) ? S_SHL_RD : S_OUT;
                            r_cnt   <= r_cnt - 1'b1;
                        end
                        default: begin
                            r_row   <= ram_rdata;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_ADD: begin
                    r_row[KeyBits + r_qi*QtyBits +: QtyBits] <= add_r;
                    if (add_ovf) r_sat <= 1'b1;
                    r_qi <= r_qi + 1'b1;
                    if (r_qi == 2'd3) r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (!r_found) r_cnt <= r_cnt + 1'b1;
                    if (r_sat) r_status <= ST_SAT;
                    r_state <= S_OUT;
                end
                S_SHL_RD: r_state <= S_SHL_WR;
                S_SHL_WR: begin
                    // r_cnt already holds the count after the remove
                    r_ptr   <= r_ptr + 1'b1;
                    r_state <= (r_ptr + 2'd2 < r_cnt + 1'b1) ? S_SHL_RD : S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata  <= {3'b0, r_cnt, (r_found || (r_status == ST_DONE &&
                                      (r_act == ACT_SET_KEY || r_act == ACT_ADD_KEY)))
                                      ? r_row[RowBits-1:KeyBits] : {(4*QtyBits){1'b0}},
                                      (r_found || (r_status == ST_DONE &&
                                      (r_act == ACT_SET_KEY || r_act == ACT_ADD_KEY)))
                                      ? r_row[KeyBits-1:0] : r_key,
                                      r_where, r_found, r_status};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
